FILE: rtl/lcdseq_pkg.sv
// Shared types, constants and helper functions of the LCD frame sequencer.
// Used by the front, back and top-level files; depends on nothing else.
`default_nettype none

package lcdseq_pkg;

	// Byte queue capacity and the size of one queued frame.
	localparam int QUEUE_DEPTH = 256;
	localparam int FRAME_BYTES = 5;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// Frames are stored one per row; a partly played frame plus whole frames.
	localparam int ROW_AW     = $clog2(QUEUE_DEPTH / FRAME_BYTES + 2);
	localparam int FRAME_ROWS = 1 << ROW_AW;

	// Item queue between the front and back parts.
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_DEV_ADDR    = 2'd0;
	localparam logic [1:0] REG_WAIT_SHORT  = 2'd1;
	localparam logic [1:0] REG_WAIT_MEDIUM = 2'd2;
	localparam logic [1:0] REG_WAIT_LONG   = 2'd3;

	localparam logic [6:0]  DEV_ADDR_RESET    = 7'h3E;
	localparam logic [15:0] WAIT_SHORT_RESET  = 16'd2;
	localparam logic [15:0] WAIT_MEDIUM_RESET = 16'd25;
	localparam logic [15:0] WAIT_LONG_RESET   = 16'd800;

	localparam logic [7:0] CTRL_COMMAND = 8'h80;
	localparam logic [7:0] CTRL_DATA    = 8'b11000000;
	localparam logic [7:0] LINE_OFFSET  = 8'h40;

	typedef enum logic [1:0] {
		FN_CMD,
		FN_DATA,
		FN_CURSOR,
		FN_TICK
	} func_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_START,
		ACT_WRITE,
		ACT_STOP
	} action_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_SEND,
		PH_STOP,
		PH_WAIT
	} phase_t;

	typedef struct packed {
		logic [6:0]  dev_addr;
		logic [15:0] wait_short;
		logic [15:0] wait_medium;
		logic [15:0] wait_long;
	} cfg_t;

	// A classified input item as it travels from front to back.
	typedef struct packed {
		logic       is_tick;
		logic       ctl_data;
		logic [7:0] data;
		logic [1:0] code;
		logic       busy;
		logic       done;
	} item_t;

	// One queued frame; the marker byte is implied.
	typedef struct packed {
		logic [6:0] addr;
		logic       ctl_data;
		logic [7:0] data;
		logic [1:0] code;
	} frame_row_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data;
		logic       accepted;
		logic       empty_idle;
	} res_t;

	// Byte at position idx of a frame in the order it is played out.
	function automatic logic [7:0] frame_byte(frame_row_t row, logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = {row.addr, 1'b0};
			3'd1:    b = row.ctl_data ? CTRL_DATA : CTRL_COMMAND;
			3'd2:    b = row.data;
			3'd4:    b = {6'd0, row.code};
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// Wait length in ticks for a wait code byte; unknown codes give one tick.
	function automatic logic [15:0] ticks_for(logic [7:0] code, cfg_t cfg);
		logic [15:0] t;
		unique case (code)
			8'd0:    t = 16'd0;
			8'd1:    t = cfg.wait_short;
			8'd2:    t = cfg.wait_medium;
			8'd3:    t = cfg.wait_long;
			default: t = 16'd1;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/i2c_lcd_frame_sequencer.sv
// Each input transaction is held in the front queue; its result is then registered in the result register.
// Throughput: one item per cycle unless the result output is held; a send tick stalls when the bytes it
// pops belong to a frame still being read out of the frame memory (registered read port).
// Reset (arst_n low, asynchronous): queue empty, sequencer idle, registers at reset values.
// Top level: configuration registers, front (lcdseq_front) and back (lcdseq_back).
// Uses lcdseq_pkg.
`default_nettype none

module i2c_lcd_frame_sequencer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// payload[7:0], wait_code[9:8], column[15:10], line[16], master_busy[17],
	// byte_done[18], zero fill[23:19]
	input  wire  [23:0] s_tdata,
	// func[1:0]
	input  wire  [1:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// bus_data[7:0], frame_accepted[8], queue_empty_idle[9], zero fill[15:10]
	output logic [15:0] m_tdata,
	// bus_action[1:0]
	output logic [1:0]  m_tuser,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lcdseq_pkg::cfg_t  cfg_q;
	lcdseq_pkg::item_t item;
	lcdseq_pkg::res_t  res;
	logic              item_valid;
	logic              item_take;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr    <= lcdseq_pkg::DEV_ADDR_RESET;
			cfg_q.wait_short  <= lcdseq_pkg::WAIT_SHORT_RESET;
			cfg_q.wait_medium <= lcdseq_pkg::WAIT_MEDIUM_RESET;
			cfg_q.wait_long   <= lcdseq_pkg::WAIT_LONG_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lcdseq_pkg::REG_DEV_ADDR:    cfg_q.dev_addr    <= pwdata[6:0];
				lcdseq_pkg::REG_WAIT_SHORT:  cfg_q.wait_short  <= pwdata[15:0];
				lcdseq_pkg::REG_WAIT_MEDIUM: cfg_q.wait_medium <= pwdata[15:0];
				lcdseq_pkg::REG_WAIT_LONG:   cfg_q.wait_long   <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lcdseq_pkg::REG_DEV_ADDR:    prdata = {25'd0, cfg_q.dev_addr};
			lcdseq_pkg::REG_WAIT_SHORT:  prdata = {16'd0, cfg_q.wait_short};
			lcdseq_pkg::REG_WAIT_MEDIUM: prdata = {16'd0, cfg_q.wait_medium};
			lcdseq_pkg::REG_WAIT_LONG:   prdata = {16'd0, cfg_q.wait_long};
		endcase
	end

	lcdseq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	lcdseq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {6'd0, res.empty_idle, res.accepted, res.data};
	assign m_tuser = res.action;

endmodule

`default_nettype wire

FILE: rtl/lcdseq_front.sv
// Front part: accepts input transactions, classifies them into items and
// holds them in a short queue for the back part. Uses lcdseq_pkg.
`default_nettype none

module lcdseq_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// payload[7:0], wait_code[9:8], column[15:10], line[16], master_busy[17],
	// byte_done[18], zero fill[23:19]
	input  wire  [23:0]          s_tdata,
	// func[1:0]
	input  wire  [1:0]           s_tuser,
	output logic                 item_valid,
	output lcdseq_pkg::item_t    item,
	input  wire                  item_take
);

	lcdseq_pkg::item_t              fq_q [lcdseq_pkg::FQ_DEPTH];
	logic [lcdseq_pkg::FQ_AW-1:0]   wr_ptr_q;
	logic [lcdseq_pkg::FQ_AW-1:0]   rd_ptr_q;
	logic [lcdseq_pkg::FQ_AW:0]     cnt_q;
	lcdseq_pkg::item_t              cls;
	lcdseq_pkg::func_t              func;
	logic [7:0]                     cursor_cmd;
	logic                           push;
	logic                           pop;

	assign func       = lcdseq_pkg::func_t'(s_tuser);
	assign cursor_cmd = lcdseq_pkg::CTRL_COMMAND |
		({2'b00, s_tdata[15:10]} + (s_tdata[16] ? lcdseq_pkg::LINE_OFFSET : 8'h00));

	always_comb begin
		cls         = '0;
		cls.busy    = s_tdata[17];
		cls.done    = s_tdata[18];
		unique case (func)
			lcdseq_pkg::FN_CMD: begin
				cls.data = s_tdata[7:0];
				cls.code = s_tdata[9:8];
			end
			lcdseq_pkg::FN_DATA: begin
				cls.ctl_data = 1'b1;
				cls.data     = s_tdata[7:0];
				cls.code     = 2'd1;
			end
			lcdseq_pkg::FN_CURSOR: begin
				cls.data = cursor_cmd;
			end
			lcdseq_pkg::FN_TICK: begin
				cls.is_tick = 1'b1;
			end
		endcase
	end

	assign s_tready   = cnt_q != (lcdseq_pkg::FQ_AW+1)'(lcdseq_pkg::FQ_DEPTH);
	assign push       = s_tvalid && s_tready;
	assign item_valid = cnt_q != '0;
	assign pop        = item_valid && item_take;
	assign item       = fq_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (lcdseq_pkg::FQ_AW+1)'(push) - (lcdseq_pkg::FQ_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fq_q[wr_ptr_q] <= cls;
	end

endmodule

`default_nettype wire

FILE: rtl/lcdseq_back.sv
// Back part: frame store, tick sequencer and result register.
// Consumes items from lcdseq_front; uses lcdseq_pkg.
`default_nettype none

module lcdseq_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lcdseq_pkg::cfg_t     cfg,
	input  wire                  item_valid,
	input  lcdseq_pkg::item_t    item,
	output logic                 item_take,
	output logic                 res_valid,
	input  wire                  res_ready,
	output lcdseq_pkg::res_t     res
);

	localparam int AW = lcdseq_pkg::ROW_AW;
	localparam int FW = lcdseq_pkg::FILL_W;

	// Frame memory and the two-row window in front of it.
	lcdseq_pkg::frame_row_t mem [lcdseq_pkg::FRAME_ROWS];
	lcdseq_pkg::frame_row_t rdata_q;
	lcdseq_pkg::frame_row_t win_q [2];
	lcdseq_pkg::frame_row_t new_row;
	logic [1:0]             win_cnt_q;
	logic                   pend_q;
	logic [AW-1:0]          wr_ptr_q;
	logic [AW-1:0]          rd_ptr_q;
	logic [AW:0]            mem_cnt_q;
	logic [2:0]             off_q;

	lcdseq_pkg::phase_t     phase_q;
	lcdseq_pkg::phase_t     phase_nx;
	logic [15:0]            wait_q;
	logic [15:0]            wait_nx;
	logic                   ready_q;
	logic                   ready_nx;
	logic [FW-1:0]          fill_q;
	logic [FW-1:0]          fill_nx;

	logic                   out_valid_q;
	lcdseq_pkg::res_t       res_q;

	logic                   ready_eff;
	logic                   tick;
	logic [7:0]             byte0;
	logic [7:0]             byte1;
	logic [7:0]             b0;
	logic [7:0]             code_byte;
	logic                   has1;
	logic                   has2;
	logic [3:0]             win_bytes;
	logic                   stall;
	logic                   fire;
	logic                   room;
	logic                   push;
	logic [1:0]             popn;
	logic [1:0]             popn_eff;
	logic [2:0]             off_sum;
	logic                   retire;
	logic [2:0]             off_nx;
	logic                   issue;
	logic [1:0]             cnt_shift;
	lcdseq_pkg::action_t    act;
	logic [7:0]             act_data;

	assign ready_eff = ready_q || item.done;
	assign tick      = item.is_tick && !item.busy;

	assign byte0 = lcdseq_pkg::frame_byte(win_q[0], off_q);
	assign byte1 = (off_q == 3'd4) ? lcdseq_pkg::frame_byte(win_q[1], 3'd0)
		: lcdseq_pkg::frame_byte(win_q[0], off_q + 3'd1);
	assign has1      = fill_q != '0;
	assign has2      = fill_q > FW'(1);
	assign b0        = has1 ? byte0 : 8'd0;
	assign code_byte = has2 ? byte1 : 8'd0;

	always_comb begin
		unique case (win_cnt_q)
			2'd0:    win_bytes = 4'd0;
			2'd1:    win_bytes = 4'd5 - {1'b0, off_q};
			default: win_bytes = 4'd10 - {1'b0, off_q};
		endcase
	end

	// A pop may need bytes of a frame that is still on its way from memory.
	assign stall = tick && phase_q == lcdseq_pkg::PH_SEND && ready_eff &&
		win_bytes < 4'd2 && fill_q > FW'(win_bytes);
	assign fire      = item_valid && !stall && (!out_valid_q || res_ready);
	assign item_take = fire;
	assign room      = fill_q <= FW'(lcdseq_pkg::QUEUE_DEPTH - lcdseq_pkg::FRAME_BYTES);
	assign push      = fire && !item.is_tick && room;

	// Next phase.
	always_comb begin
		phase_nx = phase_q;
		if (tick) begin
			unique case (phase_q)
				lcdseq_pkg::PH_IDLE: begin
					if (has1)
						phase_nx = lcdseq_pkg::PH_START;
				end
				lcdseq_pkg::PH_START: phase_nx = lcdseq_pkg::PH_SEND;
				lcdseq_pkg::PH_SEND: begin
					if (ready_eff && b0 == 8'd0)
						phase_nx = lcdseq_pkg::PH_STOP;
				end
				lcdseq_pkg::PH_STOP: phase_nx = lcdseq_pkg::PH_WAIT;
				lcdseq_pkg::PH_WAIT: begin
					if (wait_q == 16'd0)
						phase_nx = lcdseq_pkg::PH_IDLE;
				end
				default: phase_nx = lcdseq_pkg::PH_IDLE;
			endcase
		end
	end

	// Phase outputs: bus action, pops and flag updates.
	always_comb begin
		act      = lcdseq_pkg::ACT_NONE;
		act_data = 8'd0;
		popn     = 2'd0;
		ready_nx = ready_eff;
		wait_nx  = wait_q;
		if (tick) begin
			unique case (phase_q)
				lcdseq_pkg::PH_START: begin
					ready_nx = 1'b1;
					act      = lcdseq_pkg::ACT_START;
				end
				lcdseq_pkg::PH_SEND: begin
					if (ready_eff) begin
						if (b0 != 8'd0) begin
							popn     = 2'd1;
							ready_nx = 1'b0;
							act      = lcdseq_pkg::ACT_WRITE;
							act_data = b0;
						end else begin
							popn    = {1'b0, has1} + {1'b0, has2};
							wait_nx = lcdseq_pkg::ticks_for(code_byte, cfg);
						end
					end
				end
				lcdseq_pkg::PH_STOP: act = lcdseq_pkg::ACT_STOP;
				lcdseq_pkg::PH_WAIT: begin
					if (wait_q != 16'd0)
						wait_nx = wait_q - 16'd1;
				end
				default: ;
			endcase
		end
	end

	assign popn_eff = fire ? popn : 2'd0;
	assign off_sum  = off_q + {1'b0, popn_eff};
	assign retire   = off_sum >= 3'd5;
	assign off_nx   = retire ? off_sum - 3'd5 : off_sum;
	assign fill_nx  = fill_q + (push ? FW'(lcdseq_pkg::FRAME_BYTES) : FW'(0)) - FW'(popn_eff);

	// Fetch the next row whenever the window will have room for it.
	assign issue = mem_cnt_q != '0 &&
		({1'b0, win_cnt_q} + {2'b00, pend_q}) < (3'd2 + {2'b00, retire});
	assign cnt_shift = win_cnt_q - {1'b0, retire};

	assign new_row.addr     = cfg.dev_addr;
	assign new_row.ctl_data = item.ctl_data;
	assign new_row.data     = item.data;
	assign new_row.code     = item.code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lcdseq_pkg::PH_IDLE;
			wait_q      <= '0;
			ready_q     <= 1'b0;
			fill_q      <= '0;
			off_q       <= '0;
			win_cnt_q   <= '0;
			pend_q      <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			mem_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_nx;
				wait_q  <= wait_nx;
				ready_q <= ready_nx;
				fill_q  <= fill_nx;
				off_q   <= off_nx;
			end
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (issue)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			mem_cnt_q <= mem_cnt_q + (AW+1)'(push) - (AW+1)'(issue);
			pend_q    <= issue;
			win_cnt_q <= cnt_shift + {1'b0, pend_q};
			if (fire)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= new_row;
		if (issue)
			rdata_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (retire)
			win_q[0] <= win_q[1];
		if (pend_q) begin
			if (cnt_shift == 2'd0)
				win_q[0] <= rdata_q;
			else
				win_q[1] <= rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.action     <= act;
			res_q.data       <= act_data;
			res_q.accepted   <= push;
			res_q.empty_idle <= phase_nx == lcdseq_pkg::PH_IDLE && fill_nx == '0;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

	// The window never holds or awaits more than two rows.
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, win_cnt_q} + {2'b00, pend_q}) <= 3'd2)
		else $error("frame window overfilled");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(lcdseq_pkg::QUEUE_DEPTH))
		else $error("byte queue fill beyond capacity");

	// An empty byte queue leaves no rows anywhere in the frame store.
	a_empty_rows: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> (win_cnt_q == 2'd0 && mem_cnt_q == '0 && !pend_q))
		else $error("frame rows left with empty byte queue");

	a_write_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.action == lcdseq_pkg::ACT_WRITE) |-> res_q.data != 8'd0)
		else $error("zero byte written to the bus");

	a_stop_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && tick && phase_q == lcdseq_pkg::PH_STOP) |=> phase_q == lcdseq_pkg::PH_WAIT)
		else $error("stop phase did not lead to wait");

endmodule

`default_nettype wire
